>>> rtl/ups_pkg.sv
// Shared types, constants and sample arithmetic for the 2x image upscaler.
// No dependencies; every other file but ups_checker refers to it by scoped names.
`timescale 1ns / 1ps

package ups_pkg;

  localparam int PIX_W    = 8;
  localparam int SAMPLE_W = 12;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 10;
  localparam int SRCW_W   = 11;
  localparam int SRCH_W   = 12;
  localparam int ADDR_W   = 3;

  localparam logic [SRCW_W-1:0] SRC_WIDTH_RST  = SRCW_W'(5);
  localparam logic [SRCH_W-1:0] SRC_HEIGHT_RST = SRCH_W'(5);

  // Register index taken from the word address
  typedef enum logic {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } ups_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One accepted pixel with its neighbourhood, as the block stage needs it
  typedef struct packed {
    logic [PIX_W-1:0] pixel;       // current pixel
    logic [PIX_W-1:0] above;       // previous-row pixel, same column
    logic [PIX_W-1:0] above_left;  // previous-row pixel, previous column
    logic [PIX_W-1:0] left;        // current-row pixel, previous column
    sample_t          bl_prev;     // vertical sample, previous column, row above
    sample_t          lb_prev;     // extrapolated sample, previous column
    sample_t          bl_cur;      // vertical sample, this column
    sample_t          lb_cur;      // extrapolated sample, this column
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [3:0]       mask;        // blocks still owed, lowest bit first
  } ups_item_t;

  // Halve with truncation toward zero
  function automatic sample_t half(input sample_t v);
    sample_t t;
    t = v + sample_t'(v[SAMPLE_W-1]);
    return t >>> 1;
  endfunction

  // Interior new sample between two neighbours
  function automatic sample_t mid(input sample_t x, input sample_t y);
    return half(x) + half(y);
  endfunction

endpackage

>>> rtl/ups_line_buf.sv
// One-row pixel buffer: single write port, one registered read port.
// Depends on ups_pkg for the pixel width.
`timescale 1ns / 1ps

module ups_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [ups_pkg::PIX_W-1:0] wr_data_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [ups_pkg::PIX_W-1:0] rd_data_o
);

  logic [ups_pkg::PIX_W-1:0] mem [DEPTH];
  logic [ups_pkg::PIX_W-1:0] rd_q;

  // Write the current pixel, read the column of the next one
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

>>> rtl/ups_scan.sv
// Raster position counters, neighbour history and vertical samples.
// Depends on ups_pkg; drives the line buffer and feeds ups_emit.
`timescale 1ns / 1ps

module ups_scan #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              restart_i,
  input  logic [ups_pkg::SRCW_W-1:0]        src_width_i,
  input  logic [ups_pkg::SRCH_W-1:0]        src_height_i,
  input  logic                              accept_i,
  input  logic [ups_pkg::PIX_W-1:0]         pixel_i,
  input  logic [ups_pkg::PIX_W-1:0]         above_i,
  output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr_o,
  output logic                              wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      wr_addr_o,
  output logic [ups_pkg::PIX_W-1:0]         wr_data_o,
  output ups_pkg::ups_item_t                item_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = 14;

  logic [CW-1:0]                col_q, col_d;
  logic [ups_pkg::ROW_W-1:0]    row_q, row_d;
  logic [ups_pkg::PIX_W-1:0]    above_left_q, left_q;
  ups_pkg::sample_t             bl_prev_q, lb_prev_q;

  logic [WW-1:0]                w_eff, w_m1;
  logic [ups_pkg::SRCH_W-1:0]   h_eff, h_m1;
  logic                         last_col, last_row, first_row;
  logic [ups_pkg::PIX_W-1:0]    above;
  ups_pkg::sample_t             pix_s, bl_cur, lb_cur;

  // Clamp the width to 2..MAX_WIDTH, what the buffer holds, and the height to at least 2
  always_comb begin
    w_eff = WW'(src_width_i);
    if (w_eff < WW'(2)) begin
      w_eff = WW'(2);
    end
    if (w_eff > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
    h_eff = src_height_i;
    if (h_eff < ups_pkg::SRCH_W'(2)) begin
      h_eff = ups_pkg::SRCH_W'(2);
    end
  end

  assign w_m1      = w_eff - WW'(1);
  assign h_m1      = h_eff - ups_pkg::SRCH_W'(1);
  assign last_col  = (WW'(col_q) == w_m1);
  assign last_row  = (row_q == h_m1);
  assign first_row = (row_q == '0);

  // Vertical samples: interior midpoint and last-row extrapolation
  assign above  = first_row ? '0 : above_i;
  assign pix_s  = ups_pkg::sample_t'(pixel_i);
  assign bl_cur = ups_pkg::mid(ups_pkg::sample_t'(above), pix_s);
  assign lb_cur = (pix_s <<< 1) - bl_cur;

  always_comb begin
    item_o.pixel      = pixel_i;
    item_o.above      = above;
    item_o.above_left = above_left_q;
    item_o.left       = left_q;
    item_o.bl_prev    = bl_prev_q;
    item_o.lb_prev    = lb_prev_q;
    item_o.bl_cur     = bl_cur;
    item_o.lb_cur     = lb_cur;
    item_o.row        = row_q;
    item_o.col        = ups_pkg::COL_W'(col_q);
    if (first_row || col_q == '0) begin
      item_o.mask = '0;
    end else begin
      item_o.mask = {last_row && last_col, last_row, last_col, 1'b1};
    end
  end

  // Advance the raster position; a register write restarts the frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ups_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      above_left_q <= '0;
      left_q       <= '0;
      bl_prev_q    <= '0;
      lb_prev_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept_i) begin
        above_left_q <= above;
        left_q       <= pixel_i;
        bl_prev_q    <= first_row ? '0 : bl_cur;
        lb_prev_q    <= first_row ? '0 : lb_cur;
      end
    end
  end

  // Prefetch the next column so its data is registered before it is needed
  assign rd_addr_o = col_d;
  assign wr_en_o   = accept_i;
  assign wr_addr_o = col_q;
  assign wr_data_o = pixel_i;

endmodule

>>> rtl/ups_emit.sv
// Block stage: holds one item, forms its 2x2 blocks and drives the output register.
// Depends on ups_pkg for the item type and the sample arithmetic.
`timescale 1ns / 1ps

module ups_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  ups_pkg::ups_item_t            item_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ups_pkg::ROW_W-1:0]     out_row_o,
  output logic [ups_pkg::COL_W-1:0]     out_col_o,
  output ups_pkg::sample_t              out_tl_o,
  output ups_pkg::sample_t              out_tr_o,
  output ups_pkg::sample_t              out_bl_o,
  output ups_pkg::sample_t              out_br_o,
  output logic                          out_last_o
);

  ups_pkg::ups_item_t        item_q;
  logic [3:0]                mask_q, mask_d;
  logic                      out_vld_q;
  logic [ups_pkg::ROW_W-1:0] row_q;
  logic [ups_pkg::COL_W-1:0] col_q;
  ups_pkg::sample_t          tl_q, tr_q, bl_q, br_q;
  logic                      last_q;

  logic [3:0]                sel, rest;
  logic                      work_vld, out_free, fire;
  ups_pkg::sample_t          a_s, b_s, cl_s, p_s, trp, brp, trl, brl;
  logic [ups_pkg::ROW_W-1:0] row_n;
  logic [ups_pkg::COL_W-1:0] col_n;
  ups_pkg::sample_t          tl_n, tr_n, bl_n, br_n;

  // Pick the lowest owed block and what remains after it
  assign sel      = mask_q & (~mask_q + 4'd1);
  assign rest     = mask_q & (mask_q - 4'd1);
  assign work_vld = (mask_q != '0);
  assign out_free = !out_vld_q || out_ready_i;
  assign fire     = work_vld && out_free;

  assign in_ready_o = !work_vld || (out_free && rest == '0);

  // Horizontal samples from the held neighbourhood
  assign a_s  = ups_pkg::sample_t'(item_q.above_left);
  assign b_s  = ups_pkg::sample_t'(item_q.above);
  assign cl_s = ups_pkg::sample_t'(item_q.left);
  assign p_s  = ups_pkg::sample_t'(item_q.pixel);
  assign trp  = ups_pkg::mid(a_s, b_s);
  assign brp  = ups_pkg::mid(item_q.bl_prev, item_q.bl_cur);
  assign trl  = ups_pkg::mid(cl_s, p_s);
  assign brl  = ups_pkg::mid(item_q.lb_prev, item_q.lb_cur);

  always_comb begin
    case (sel)
      4'b0001: begin
        row_n = item_q.row - ups_pkg::ROW_W'(1);
        col_n = item_q.col - ups_pkg::COL_W'(1);
        tl_n  = a_s;
        tr_n  = trp;
        bl_n  = item_q.bl_prev;
        br_n  = brp;
      end
      4'b0010: begin
        row_n = item_q.row - ups_pkg::ROW_W'(1);
        col_n = item_q.col;
        tl_n  = b_s;
        tr_n  = (b_s <<< 1) - trp;
        bl_n  = item_q.bl_cur;
        br_n  = (item_q.bl_cur <<< 1) - brp;
      end
      4'b0100: begin
        row_n = item_q.row;
        col_n = item_q.col - ups_pkg::COL_W'(1);
        tl_n  = cl_s;
        tr_n  = trl;
        bl_n  = item_q.lb_prev;
        br_n  = brl;
      end
      default: begin
        row_n = item_q.row;
        col_n = item_q.col;
        tl_n  = p_s;
        tr_n  = (p_s <<< 1) - trl;
        bl_n  = item_q.lb_cur;
        br_n  = (item_q.lb_cur <<< 1) - brl;
      end
    endcase
  end

  // Load a new item over the finished one, else drop the block just sent
  always_comb begin
    mask_d = mask_q;
    if (accept_i) begin
      mask_d = item_i.mask;
    end else if (fire) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
    if (fire) begin
      row_q  <= row_n;
      col_q  <= col_n;
      tl_q   <= tl_n;
      tr_q   <= tr_n;
      bl_q   <= bl_n;
      br_q   <= br_n;
      last_q <= (rest == '0);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign out_tl_o    = tl_q;
  assign out_tr_o    = tr_q;
  assign out_bl_o    = bl_q;
  assign out_br_o    = br_q;
  assign out_last_o  = last_q;

endmodule

>>> rtl/linear_2x_image_upscaler.sv
// Streaming 2x upscaler for 8-bit grey images. Source pixels enter in raster order on
// the slave stream; each pixel owns one 2x2 output block (original pixel top left,
// new samples made down columns first, then along rows, extrapolated at the last row
// and column). A block leaves once its neighbours are known, so a pixel releases
// none (first row or column), one, two (last column or last row) or four (last
// pixel of the frame) blocks, with tlast on the final one. A pixel is taken every
// cycle while the previous pixel owes at most one more block and the output register
// is free; the output register sends one block per cycle unless m_tready stalls it.
// One row of source pixels sits in a MAX_WIDTH x 8 single-port-write buffer; it needs
// no clearing pass. Writing either size register restarts the frame at row 0, col 0.
// Depends on ups_pkg, ups_line_buf, ups_scan and ups_emit.
`timescale 1ns / 1ps

module linear_2x_image_upscaler #(
  parameter int MAX_WIDTH = 1024,
  parameter int OUT_BITS  = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ups_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Source pixels
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] pixel
  // Output blocks
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [11:0] block_row, [21:12] block_col, then top_left, top_right, bottom_left,
  // bottom_right at OUT_BITS each, zero fill to a whole byte
  output logic [((22+4*OUT_BITS+7)/8)*8-1:0] m_tdata,
  output logic                              m_tlast    // last
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int M_DATA_W = ((22 + 4 * OUT_BITS + 7) / 8) * 8;

  logic [ups_pkg::SRCW_W-1:0] src_width_q;
  logic [ups_pkg::SRCH_W-1:0] src_height_q;
  logic                       cfg_wr;
  ups_pkg::ups_reg_e          reg_idx;

  logic                       accept;
  logic                       in_ready;
  logic [CW-1:0]              rd_addr, wr_addr;
  logic                       wr_en;
  logic [ups_pkg::PIX_W-1:0]  wr_data, rd_data;
  ups_pkg::ups_item_t         item;

  logic [ups_pkg::ROW_W-1:0]  out_row;
  logic [ups_pkg::COL_W-1:0]  out_col;
  ups_pkg::sample_t           out_tl, out_tr, out_bl, out_br;
  logic signed [OUT_BITS-1:0] tl_x, tr_x, bl_x, br_x;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = ups_pkg::ups_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= ups_pkg::SRC_WIDTH_RST;
      src_height_q <= ups_pkg::SRC_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ups_pkg::REG_SRC_WIDTH:  src_width_q  <= pwdata[ups_pkg::SRCW_W-1:0];
        ups_pkg::REG_SRC_HEIGHT: src_height_q <= pwdata[ups_pkg::SRCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ups_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width_q);
      ups_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height_q);
      default:                 prdata = '0;
    endcase
  end

  // Input transfer
  assign s_tready = in_ready;
  assign accept   = s_tvalid && in_ready;

  ups_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ups_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_wr),
    .src_width_i  (src_width_q),
    .src_height_i (src_height_q),
    .accept_i     (accept),
    .pixel_i      (s_tdata),
    .above_i      (rd_data),
    .rd_addr_o    (rd_addr),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .item_o       (item)
  );

  ups_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .in_ready_o  (in_ready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_tl_o    (out_tl),
    .out_tr_o    (out_tr),
    .out_bl_o    (out_bl),
    .out_br_o    (out_br),
    .out_last_o  (m_tlast)
  );

  // Sign-extend the samples and pack the output word
  assign tl_x = OUT_BITS'(out_tl);
  assign tr_x = OUT_BITS'(out_tr);
  assign bl_x = OUT_BITS'(out_bl);
  assign br_x = OUT_BITS'(out_br);

  assign m_tdata = M_DATA_W'({br_x, bl_x, tr_x, tl_x, out_col, out_row});

endmodule

>>> rtl/ups_checker.sv
// Port-level checks for the 2x upscaler, attached to the top level by bind.
// Depends only on the top level's ports and OUT_BITS.
`timescale 1ns / 1ps

module ups_checker #(
  parameter int OUT_BITS = 12
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [((22+4*OUT_BITS+7)/8)*8-1:0] m_tdata,
  input logic                               m_tlast
);

  // Hold a stalled block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output block withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output block changed while stalled");

  // Remaining blocks of a pixel follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside the blocks of one pixel");

  // The top-left sample is always an original 8-bit pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[22+8 +: OUT_BITS-8] == '0)
    else $error("top-left sample outside the pixel range");

endmodule

bind linear_2x_image_upscaler ups_checker #(.OUT_BITS(OUT_BITS)) u_ups_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> tb/sv/linear_2x_image_upscaler_tb.sv
// Self-checking testbench for the streaming 2x image upscaler: directed table,
// then random frames under varying back-pressure, checked block by block.
// Depends on ups_pkg and linear_2x_image_upscaler.
`timescale 1ns / 1ps

module linear_2x_image_upscaler_tb;

  localparam int MAX_WIDTH      = 1024;
  localparam int RANDOM_PIXELS  = 350;
  localparam int WIDE_PIXELS    = 24;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_STEPS      = 22;
  localparam int TDATA_W        = ((22 + 4 * ups_pkg::SAMPLE_W + 7) / 8) * 8;

  // Bit offsets of the block fields in m_tdata
  localparam int OFS_COL = ups_pkg::ROW_W;
  localparam int OFS_TL  = ups_pkg::ROW_W + ups_pkg::COL_W;
  localparam int OFS_TR  = OFS_TL + ups_pkg::SAMPLE_W;
  localparam int OFS_BL  = OFS_TR + ups_pkg::SAMPLE_W;
  localparam int OFS_BR  = OFS_BL + ups_pkg::SAMPLE_W;

  typedef struct packed {
    logic [ups_pkg::ROW_W-1:0] row;
    logic [ups_pkg::COL_W-1:0] col;
    ups_pkg::sample_t          tl;
    ups_pkg::sample_t          tr;
    ups_pkg::sample_t          bl;
    ups_pkg::sample_t          br;
    logic                      last;
  } out_block_t;

  // Typed samples that override the first block a pixel releases
  typedef struct packed {
    logic             typed;
    ups_pkg::sample_t tl;
    ups_pkg::sample_t tr;
    ups_pkg::sample_t bl;
    ups_pkg::sample_t br;
  } pixel_note_t;

  typedef enum logic [1:0] {
    STEP_WIDTH,
    STEP_HEIGHT,
    STEP_PIXEL
  } step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    logic [31:0] value;
    pixel_note_t note;
  } step_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [ups_pkg::ADDR_W-1:0]   paddr   = '0;
  logic [31:0]                  pwdata  = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = '0;   // [7:0] pixel

  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [11:0] block_row, [21:12] block_col, [33:22] top_left, [45:34] top_right,
  // [57:46] bottom_left, [69:58] bottom_right, [71:70] zero fill
  logic [TDATA_W-1:0]    m_tdata;
  logic                  m_tlast;         // last

  // Predictor state: configuration, one source row and the left-hand history
  logic [ups_pkg::SRCW_W-1:0] size_w = ups_pkg::SRC_WIDTH_RST;
  logic [ups_pkg::SRCH_W-1:0] size_h = ups_pkg::SRC_HEIGHT_RST;
  logic [7:0]        line_pix [MAX_WIDTH];
  int                left_px;
  int                diag_px;
  int                vert_left;
  int                extrap_left;
  int                col_pos;
  int                row_pos;

  out_block_t  blocks_due [$];
  pixel_note_t pixel_notes [$];
  step_t       dir_steps [DIR_STEPS];

  int          mismatches;
  int          idle_run;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned send_gap_by_phase [4] = '{0, 86, 0, 37};
  int unsigned recv_stall_by_phase [4] = '{0, 0, 86, 37};

  out_block_t  got_block;

  linear_2x_image_upscaler u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  // Halve with truncation toward zero
  function automatic int halve(input int v);
    return v / 2;
  endfunction

  function automatic out_block_t make_block(input int r, input int c, input int tl,
                                            input int tr, input int bl, input int br);
    out_block_t b;
    b.row  = ups_pkg::ROW_W'(r);
    b.col  = ups_pkg::COL_W'(c);
    b.tl   = ups_pkg::SAMPLE_W'(tl);
    b.tr   = ups_pkg::SAMPLE_W'(tr);
    b.bl   = ups_pkg::SAMPLE_W'(bl);
    b.br   = ups_pkg::SAMPLE_W'(br);
    b.last = 1'b0;
    return b;
  endfunction

  // Work out the blocks that one source pixel releases and queue them
  function automatic void upscale_pixel(input logic [7:0] px, input pixel_note_t note);
    out_block_t made [4];
    int n, w, h, r, c, p, above, vert, extrap, top_mid, bot_mid, top_last, bot_last, i;
    n = 0;
    w = int'(size_w);
    h = int'(size_h);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 2) h = 2;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    p = int'(px);
    above = 0;
    if (r >= 1) begin
      above  = int'(line_pix[c]);
      vert   = halve(above) + halve(p);
      extrap = (r == h - 1) ? 2 * p - vert : 0;
      if (c >= 1) begin
        top_mid = halve(diag_px) + halve(above);
        bot_mid = halve(vert_left) + halve(vert);
        made[n] = make_block(r - 1, c - 1, diag_px, top_mid, vert_left, bot_mid);
        n++;
        if (c == w - 1) begin
          made[n] = make_block(r - 1, c, above, 2 * above - top_mid, vert,
                               2 * vert - bot_mid);
          n++;
        end
        if (r == h - 1) begin
          top_last = halve(left_px) + halve(p);
          bot_last = halve(extrap_left) + halve(extrap);
          made[n] = make_block(r, c - 1, left_px, top_last, extrap_left, bot_last);
          n++;
          if (c == w - 1) begin
            made[n] = make_block(r, c, p, 2 * p - top_last, extrap,
                                 2 * extrap - bot_last);
            n++;
          end
        end
      end
      vert_left   = vert;
      extrap_left = extrap;
    end else begin
      vert_left   = 0;
      extrap_left = 0;
    end
    diag_px     = above;
    line_pix[c] = px;
    left_px     = p;

    if (n > 0) begin
      made[n-1].last = 1'b1;
      if (note.typed) begin
        made[0].tl = note.tl;
        made[0].tr = note.tr;
        made[0].bl = note.bl;
        made[0].br = note.br;
      end
    end
    for (i = 0; i < n; i++) blocks_due.push_back(made[i]);

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic void compare_block(input out_block_t want, input out_block_t got);
    if (got.row !== want.row) flag_mismatch("block_row", int'(want.row), int'(got.row));
    if (got.col !== want.col) flag_mismatch("block_col", int'(want.col), int'(got.col));
    if (got.tl !== want.tl) flag_mismatch("top_left", int'(want.tl), int'(got.tl));
    if (got.tr !== want.tr) flag_mismatch("top_right", int'(want.tr), int'(got.tr));
    if (got.bl !== want.bl) flag_mismatch("bottom_left", int'(want.bl), int'(got.bl));
    if (got.br !== want.br) flag_mismatch("bottom_right", int'(want.br), int'(got.br));
    if (got.last !== want.last) flag_mismatch("last", int'(want.last), int'(got.last));
  endfunction

  // Predict on each pixel transfer, check each block transfer, guard against hangs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        upscale_pixel(s_tdata, pixel_notes.pop_front());
      end
      if (m_tvalid && m_tready) begin
        got_block.row  = m_tdata[0 +: ups_pkg::ROW_W];
        got_block.col  = m_tdata[OFS_COL +: ups_pkg::COL_W];
        got_block.tl   = m_tdata[OFS_TL +: ups_pkg::SAMPLE_W];
        got_block.tr   = m_tdata[OFS_TR +: ups_pkg::SAMPLE_W];
        got_block.bl   = m_tdata[OFS_BL +: ups_pkg::SAMPLE_W];
        got_block.br   = m_tdata[OFS_BR +: ups_pkg::SAMPLE_W];
        got_block.last = m_tlast;
        if (blocks_due.size() == 0) begin
          flag_mismatch("block with none outstanding, row", 0, int'(got_block.row));
        end else begin
          compare_block(blocks_due.pop_front(), got_block);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        idle_run = 0;
      end else begin
        idle_run++;
        if (idle_run >= WATCHDOG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one pixel, idling first at the current rate, and hold until transferred
  task automatic send_pixel(input logic [7:0] px, input pixel_note_t note);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    pixel_notes.push_back(note);
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Drop valid and wait until every block is out and the pipeline is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (blocks_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write of a size register, then read it back
  task automatic set_size_reg(input ups_pkg::ups_reg_e idx, input logic [31:0] val);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ups_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // The register takes the value at this edge and the frame restarts
    if (idx == ups_pkg::REG_SRC_WIDTH) begin
      size_w = val[ups_pkg::SRCW_W-1:0];
      want   = 32'(size_w);
    end else begin
      size_h = val[ups_pkg::SRCH_W-1:0];
      want   = 32'(size_h);
    end
    col_pos = 0;
    row_pos = 0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) flag_mismatch("register read-back", int'(want), int'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    step_t       step;
    pixel_note_t plain;
    int          i, w, h, w_eff, h_eff, n, phase, sent;

    plain       = '0;
    mismatches  = 0;
    idle_run    = 0;
    left_px     = 0;
    diag_px     = 0;
    vert_left   = 0;
    extrap_left = 0;
    col_pos     = 0;
    row_pos     = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (i = 0; i < MAX_WIDTH; i++) line_pix[i] = '0;

    // Directed: clamped 2x2 frames of full scale, of zero, and with a
    // falling edge that drives the extrapolation negative; then a 3x2 checker
    dir_steps = '{
      '{STEP_WIDTH,  32'd1,   '0},
      '{STEP_HEIGHT, 32'd0,   '0},
      '{STEP_PIXEL,  32'd255, '0},
      '{STEP_PIXEL,  32'd255, '0},
      '{STEP_PIXEL,  32'd255, '0},
      '{STEP_PIXEL,  32'd255, '{1'b1, 12'sd255, 12'sd254, 12'sd254, 12'sd254}},
      '{STEP_PIXEL,  32'd0,   '0},
      '{STEP_PIXEL,  32'd0,   '0},
      '{STEP_PIXEL,  32'd0,   '0},
      '{STEP_PIXEL,  32'd0,   '{1'b1, 12'sd0, 12'sd0, 12'sd0, 12'sd0}},
      '{STEP_PIXEL,  32'd255, '0},
      '{STEP_PIXEL,  32'd255, '0},
      '{STEP_PIXEL,  32'd0,   '0},
      '{STEP_PIXEL,  32'd0,   '{1'b1, 12'sd255, 12'sd254, 12'sd127, 12'sd126}},
      '{STEP_HEIGHT, 32'd1,   '0},
      '{STEP_WIDTH,  32'd3,   '0},
      '{STEP_PIXEL,  32'd0,   '0},
      '{STEP_PIXEL,  32'd255, '0},
      '{STEP_PIXEL,  32'd0,   '0},
      '{STEP_PIXEL,  32'd255, '0},
      '{STEP_PIXEL,  32'd0,   '0},
      '{STEP_PIXEL,  32'd255, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_STEPS; i++) begin
      step = dir_steps[i];
      case (step.kind)
        STEP_WIDTH: begin
          settle();
          set_size_reg(ups_pkg::REG_SRC_WIDTH, step.value);
        end
        STEP_HEIGHT: begin
          settle();
          set_size_reg(ups_pkg::REG_SRC_HEIGHT, step.value);
        end
        default: send_pixel(step.value[7:0], step.note);
      endcase
    end

    // Random frames, mostly whole ones, cycling through the pressure phases
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      settle();
      send_gap_pct   = send_gap_by_phase[phase % 4];
      recv_stall_pct = recv_stall_by_phase[phase % 4];
      w = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 9);
      h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 6);
      set_size_reg(ups_pkg::REG_SRC_WIDTH, 32'(w));
      set_size_reg(ups_pkg::REG_SRC_HEIGHT, 32'(h));
      w_eff = (w < 2) ? 2 : w;
      h_eff = (h < 2) ? 2 : h;
      n = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(w_eff);
      repeat (n) send_pixel(random_pixel(), plain);
      sent += n;
      phase++;
    end

    // Width beyond the buffer clamps, tallest height: start of a long first row
    settle();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    set_size_reg(ups_pkg::REG_SRC_WIDTH, 32'h7FF);
    set_size_reg(ups_pkg::REG_SRC_HEIGHT, 32'hFFF);
    repeat (WIDE_PIXELS) send_pixel(random_pixel(), plain);

    settle();
    if (mismatches == 0 && blocks_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ups_pkg.sv
rtl/ups_line_buf.sv
rtl/ups_scan.sv
rtl/ups_emit.sv
rtl/linear_2x_image_upscaler.sv
rtl/ups_checker.sv
tb/sv/linear_2x_image_upscaler_tb.sv
